### rtl/core/tlvp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlvp_pkg
// Types and constants for the TLV block stream parser: parser phases, event
// codes and the special byte values of the block format.
// ----------------------------------------------------------------------------
package tlvp_pkg;

    localparam logic [7:0] NULL_BYTE = 8'h00;
    localparam logic [7:0] TERM_BYTE = 8'hFE;
    localparam logic [7:0] LONG_LEN  = 8'hFF;

    typedef enum logic [2:0] {
        PH_TYPE  = 3'd0,
        PH_LEN   = 3'd1,
        PH_LENHI = 3'd2,
        PH_LENLO = 3'd3,
        PH_VALUE = 3'd4,
        PH_STOP  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_HEADER = 3'd0,
        EV_VALUE  = 3'd1,
        EV_EMPTY  = 3'd2,
        EV_TERM   = 3'd3,
        EV_TRUNC  = 3'd4,
        EV_IGNORE = 3'd5
    } event_t;

endpackage
`default_nettype wire

### rtl/core/tlvp_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlvp_in_if
// Byte channel into the parser: one raw area byte and its last-byte flag per
// transaction.
// ----------------------------------------------------------------------------
interface tlvp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       area_last;

    modport source (output valid, output data_byte, output area_last, input ready);
    modport sink   (input valid, input data_byte, input area_last, output ready);

endinterface
`default_nettype wire

### rtl/core/tlvp_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlvp_out_if
// Event channel out of the parser: one parse event per transaction.
// ----------------------------------------------------------------------------
interface tlvp_out_if;

    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  block_type;
    logic [7:0]  value_byte;
    logic [15:0] value_index;
    logic        block_last;
    logic        sequence_ok;

    modport source (
        output valid, output event_res, output block_type, output value_byte,
        output value_index, output block_last, output sequence_ok, input ready
    );
    modport sink (
        input valid, input event_res, input block_type, input value_byte,
        input value_index, input block_last, input sequence_ok, output ready
    );

endinterface
`default_nettype wire

### rtl/core/tlv_block_stream_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlv_block_stream_parser_core
// Splits a stream of tag memory bytes into TLV blocks and reports one event
// per byte: header, value, empty block, terminator, truncation or ignored.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                          | flow
//  bytes    | in  | data_byte, area_last                             | valid/ready
//  events   | out | event_res, block_type, value_byte, value_index,  | valid/ready
//           |     | block_last, sequence_ok                          |
//
//  One byte in, one event out; a byte is taken every cycle while the event channel does not stall.
//  The parser state and the event register update at the edge that takes the byte.
//  A byte is taken whenever the event register is empty or being drained.
//  Reset puts the parser in the expect-type phase with an empty event register.
// ----------------------------------------------------------------------------
module tlv_block_stream_parser_core
    import tlvp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tlvp_in_if.sink     bytes,
    tlvp_out_if.source  events
);

    phase_t      phase_reg,  phase_next;
    logic [7:0]  type_reg,   type_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] left_reg,   left_next;
    logic [15:0] pos_reg,    pos_next;

    logic        valid_reg;
    event_t      ev_reg,     ev_next;
    logic [7:0]  btype_reg,  btype_next;
    logic [7:0]  vbyte_reg,  vbyte_next;
    logic [15:0] vindex_reg, vindex_next;
    logic        blast_reg,  blast_next;
    logic        ok_reg,     ok_next;

    logic        accept;
    logic [15:0] len_val;

    assign bytes.ready = !valid_reg || events.ready;
    assign accept      = bytes.valid && bytes.ready;

    assign len_val = (phase_reg == PH_LEN) ? {8'd0, bytes.data_byte}
                                           : {len_hi_reg, bytes.data_byte};

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        len_hi_next = len_hi_reg;
        left_next   = left_reg;
        pos_next    = pos_reg;
        ev_next     = EV_HEADER;
        btype_next  = 8'd0;
        vbyte_next  = 8'd0;
        vindex_next = 16'd0;
        blast_next  = 1'b0;
        ok_next     = 1'b0;

        case (phase_reg)
            PH_TYPE:
            begin
                if (bytes.data_byte == NULL_BYTE)
                begin
                    ev_next = EV_HEADER;
                end
                else if (bytes.data_byte == TERM_BYTE)
                begin
                    ev_next    = EV_TERM;
                    btype_next = TERM_BYTE;
                    phase_next = PH_STOP;
                end
                else
                begin
                    type_next  = bytes.data_byte;
                    btype_next = bytes.data_byte;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN, PH_LENLO:
            begin
                btype_next = type_reg;
                if (phase_reg == PH_LEN && bytes.data_byte == LONG_LEN)
                begin
                    phase_next = PH_LENHI;
                end
                else if (len_val == 16'd0)
                begin
                    ev_next    = EV_EMPTY;
                    blast_next = 1'b1;
                    phase_next = PH_TYPE;
                end
                else
                begin
                    left_next  = len_val;
                    pos_next   = 16'd0;
                    phase_next = PH_VALUE;
                end
            end
            PH_LENHI:
            begin
                len_hi_next = bytes.data_byte;
                btype_next  = type_reg;
                phase_next  = PH_LENLO;
            end
            PH_VALUE:
            begin
                ev_next     = EV_VALUE;
                btype_next  = type_reg;
                vbyte_next  = bytes.data_byte;
                vindex_next = pos_reg;
                blast_next  = (left_reg == 16'd1);
                left_next   = left_reg - 16'd1;
                pos_next    = pos_reg + 16'd1;
                if (left_reg == 16'd1)
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_STOP:
            begin
                ev_next = EV_IGNORE;
            end
            default:
            begin
                // recover to the start state
                phase_next  = PH_TYPE;
                type_next   = 8'd0;
                len_hi_next = 8'd0;
                left_next   = 16'd0;
                pos_next    = 16'd0;
                ev_next     = EV_IGNORE;
            end
        endcase

        if (bytes.area_last)
        begin
            if (phase_next == PH_STOP)
            begin
                ok_next = 1'b1;
            end
            else if (phase_next != PH_TYPE)
            begin
                ev_next     = EV_TRUNC;
                btype_next  = type_next;
                vbyte_next  = bytes.data_byte;
                vindex_next = 16'd0;
                blast_next  = 1'b0;
                ok_next     = 1'b0;
            end
            phase_next  = PH_TYPE;
            type_next   = 8'd0;
            len_hi_next = 8'd0;
            left_next   = 16'd0;
            pos_next    = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            type_reg   <= 8'd0;
            len_hi_reg <= 8'd0;
            left_reg   <= 16'd0;
            pos_reg    <= 16'd0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                type_reg   <= type_next;
                len_hi_reg <= len_hi_next;
                left_reg   <= left_next;
                pos_reg    <= pos_next;
                valid_reg  <= 1'b1;
            end
            else if (events.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg     <= ev_next;
            btype_reg  <= btype_next;
            vbyte_reg  <= vbyte_next;
            vindex_reg <= vindex_next;
            blast_reg  <= blast_next;
            ok_reg     <= ok_next;
        end
    end

    assign events.valid       = valid_reg;
    assign events.event_res   = ev_reg;
    assign events.block_type  = btype_reg;
    assign events.value_byte  = vbyte_reg;
    assign events.value_index = vindex_reg;
    assign events.block_last  = blast_reg;
    assign events.sequence_ok = ok_reg;

    a_area_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && bytes.area_last |=> phase_reg == PH_TYPE && pos_reg == 16'd0)
        else $error("parser not back at start after area end");

    a_ok_only_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && ok_reg |-> ev_reg == EV_TERM || ev_reg == EV_IGNORE)
        else $error("sequence_ok without terminator event");

    a_last_only_on_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && blast_reg |-> ev_reg == EV_VALUE || ev_reg == EV_EMPTY)
        else $error("block_last on non-completing event");

    a_value_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VALUE |-> left_reg != 16'd0)
        else $error("value phase with no bytes left");

    a_index_only_on_value: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && vindex_reg != 16'd0 |-> ev_reg == EV_VALUE)
        else $error("value_index set on non-value event");

endmodule
`default_nettype wire

### tb/sv/tlv_event_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlv_event_checker
// Watches the byte and event channels of the TLV block stream parser. Every
// byte taken is run through a local copy of the parser state to work out the
// event it must cause. Every event taken is compared, field by field, with
// the oldest event still awaited.
// ----------------------------------------------------------------------------
module tlv_event_checker
    import tlvp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  in_data,
    input  wire logic        in_last,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [2:0]  out_event,
    input  wire logic [7:0]  out_type,
    input  wire logic [7:0]  out_value,
    input  wire logic [15:0] out_index,
    input  wire logic        out_block_last,
    input  wire logic        out_sequence_ok,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        event_t      code;
        logic [7:0]  block_type;
        logic [7:0]  value_byte;
        logic [15:0] value_index;
        logic        block_last;
        logic        sequence_ok;
    } tlv_event_t;

    phase_t      ph;
    logic [7:0]  cur_type;
    logic [7:0]  len_hi;
    logic [15:0] bytes_left;
    logic [15:0] value_pos;

    tlv_event_t  awaited_events[$];

    function automatic void clear_parser();
        ph         = PH_TYPE;
        cur_type   = 8'h00;
        len_hi     = 8'h00;
        bytes_left = 16'd0;
        value_pos  = 16'd0;
    endfunction

    function automatic tlv_event_t parse_byte(input logic [7:0] b, input logic last);
        tlv_event_t  ev;
        logic [15:0] len;
        logic        start;
        ev    = '0;
        len   = 16'd0;
        start = 1'b0;
        case (ph)
            PH_TYPE:
            begin
                if (b == NULL_BYTE)
                begin
                    ev.code = EV_HEADER;
                end
                else if (b == TERM_BYTE)
                begin
                    ev.code       = EV_TERM;
                    ev.block_type = TERM_BYTE;
                    ph            = PH_STOP;
                end
                else
                begin
                    cur_type      = b;
                    ev.code       = EV_HEADER;
                    ev.block_type = b;
                    ph            = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (b == LONG_LEN)
                begin
                    ev.code       = EV_HEADER;
                    ev.block_type = cur_type;
                    ph            = PH_LENHI;
                end
                else
                begin
                    len   = {8'h00, b};
                    start = 1'b1;
                end
            end
            PH_LENHI:
            begin
                len_hi        = b;
                ev.code       = EV_HEADER;
                ev.block_type = cur_type;
                ph            = PH_LENLO;
            end
            PH_LENLO:
            begin
                len   = {len_hi, b};
                start = 1'b1;
            end
            PH_VALUE:
            begin
                ev.code        = EV_VALUE;
                ev.block_type  = cur_type;
                ev.value_byte  = b;
                ev.value_index = value_pos;
                ev.block_last  = (bytes_left == 16'd1);
                bytes_left     = bytes_left - 16'd1;
                value_pos      = value_pos + 16'd1;
                if (bytes_left == 16'd0)
                    ph = PH_TYPE;
            end
            PH_STOP:
            begin
                ev.code = EV_IGNORE;
            end
            default:
            begin
                clear_parser();
                ev.code = EV_IGNORE;
            end
        endcase
        if (start)
        begin
            ev.block_type = cur_type;
            if (len == 16'd0)
            begin
                ev.code       = EV_EMPTY;
                ev.block_last = 1'b1;
                ph            = PH_TYPE;
            end
            else
            begin
                ev.code    = EV_HEADER;
                bytes_left = len;
                value_pos  = 16'd0;
                ph         = PH_VALUE;
            end
        end
        if (last)
        begin
            if (ph == PH_STOP)
            begin
                ev.sequence_ok = 1'b1;
            end
            else if (ph != PH_TYPE)
            begin
                ev            = '0;
                ev.code       = EV_TRUNC;
                ev.block_type = cur_type;
                ev.value_byte = b;
            end
            clear_parser();
        end
        return ev;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        tlv_event_t want;
        if (!rst_n)
        begin
            clear_parser();
            awaited_events.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_events.size() == 0)
                begin
                    $error("event transaction with no byte awaiting it");
                    fail_count++;
                end
                else
                begin
                    want = awaited_events.pop_front();
                    check_field("event_res", 16'(want.code), 16'(out_event));
                    check_field("block_type", 16'(want.block_type), 16'(out_type));
                    check_field("value_byte", 16'(want.value_byte), 16'(out_value));
                    check_field("value_index", want.value_index, out_index);
                    check_field("block_last", 16'(want.block_last), 16'(out_block_last));
                    check_field("sequence_ok", 16'(want.sequence_ok), 16'(out_sequence_ok));
                end
            end
            if (in_valid && in_ready)
                awaited_events.push_back(parse_byte(in_data, in_last));
            pending = awaited_events.size();
        end
    end

endmodule
`default_nettype wire

### tb/sv/tlv_block_stream_parser_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlv_block_stream_parser_core_tb
// Feeds the TLV block stream parser with tag memory areas: a few hand-built
// areas for the corner cases, then random areas of well-formed blocks with
// nulls, long lengths, terminators, trailing bytes and truncation, mixed with
// pure noise. Both channels idle in random bursts except near the end. A
// checker beside the parser predicts and compares every event.
// ----------------------------------------------------------------------------
module tlv_block_stream_parser_core_tb;
    import tlvp_pkg::*;

    localparam int ITEM_TARGET = 1350;
    localparam int CALM_FROM   = 1150;
    localparam int CYCLE_LIMIT = 400000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic calm  = 1'b0;
    int   bytes_sent = 0;
    int   cycles     = 0;
    int   fail_count;
    int   pending;

    logic [7:0] area_bytes[$];

    tlvp_in_if  byte_ch ();
    tlvp_out_if event_ch ();

    tlv_block_stream_parser_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (byte_ch),
        .events (event_ch)
    );

    tlv_event_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (byte_ch.valid),
        .in_ready        (byte_ch.ready),
        .in_data         (byte_ch.data_byte),
        .in_last         (byte_ch.area_last),
        .out_valid       (event_ch.valid),
        .out_ready       (event_ch.ready),
        .out_event       (event_ch.event_res),
        .out_type        (event_ch.block_type),
        .out_value       (event_ch.value_byte),
        .out_index       (event_ch.value_index),
        .out_block_last  (event_ch.block_last),
        .out_sequence_ok (event_ch.sequence_ok),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.area_last <= last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_sent++;
        calm = (bytes_sent >= CALM_FROM);
    endtask

    task automatic send_area();
        foreach (area_bytes[i])
            send_byte(area_bytes[i], i == area_bytes.size() - 1);
    endtask

    task automatic build_area();
        int         len;
        int         mode;
        logic [7:0] kind;
        area_bytes.delete();
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 20))
                area_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 5))
        begin
            if ($urandom_range(0, 5) == 0)
                area_bytes.push_back(NULL_BYTE);
            kind = 8'($urandom_range(1, 254));
            if (kind == TERM_BYTE)
                kind = LONG_LEN;
            area_bytes.push_back(kind);
            mode = $urandom_range(0, 9);
            if (mode < 6)
            begin
                len = $urandom_range(0, 8);
                area_bytes.push_back(8'(len));
            end
            else if (mode == 6)
            begin
                len = $urandom_range(9, 254);
                area_bytes.push_back(8'(len));
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(256, 300);
                else
                    len = $urandom_range(0, 12);
                area_bytes.push_back(LONG_LEN);
                area_bytes.push_back(8'(len >> 8));
                area_bytes.push_back(8'(len));
            end
            repeat (len)
                area_bytes.push_back(8'($urandom_range(0, 255)));
        end
        mode = $urandom_range(0, 9);
        if (mode < 5)
        begin
            area_bytes.push_back(TERM_BYTE);
            repeat ($urandom_range(0, 3))
                area_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (mode >= 7)
        begin
            area_bytes.push_back(8'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 3))
                area_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (area_bytes.size() == 0)
            area_bytes.push_back(NULL_BYTE);
    endtask

    task automatic drive_ready();
        forever
        begin
            if (!calm && rst_n && $urandom_range(0, 7) == 0)
            begin
                event_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            event_ch.ready <= 1'b1;
            @(posedge clk);
        end
    endtask

    task automatic drive_bytes();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // null, block with a terminator-valued value byte, terminator, ignored tail
        area_bytes = '{8'h00, 8'h03, 8'h02, 8'hFE, 8'h11, 8'hFE, 8'h66};
        send_area();
        // long-form zero length, terminator as the area's last byte
        area_bytes = '{8'h01, 8'hFF, 8'h00, 8'h00, 8'hFE};
        send_area();
        // truncated value, terminator value as the last data byte
        area_bytes = '{8'hFF, 8'h05, 8'hAA, 8'hFE};
        send_area();
        // long-form length, area ends before any value byte (truncation)
        area_bytes = '{8'h02, 8'hFF, 8'hFF, 8'h80};
        send_area();
        // lone null byte as the whole area
        area_bytes = '{8'h00};
        send_area();
        // empty block, then a block completed on the area's last byte
        area_bytes = '{8'h7F, 8'h00, 8'hFD, 8'h01, 8'hFE};
        send_area();

        while (bytes_sent < ITEM_TARGET)
        begin
            build_area();
            send_area();
        end
        byte_ch.valid <= 1'b0;

        do
            @(negedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    endtask

    initial
    begin
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = 8'h00;
        byte_ch.area_last  = 1'b0;
        event_ch.ready     = 1'b0;
        fork
            drive_ready();
            drive_bytes();
        join
    end

endmodule
`default_nettype wire

### sim.f
rtl/core/tlvp_pkg.sv
rtl/core/tlvp_in_if.sv
rtl/core/tlvp_out_if.sv
rtl/core/tlv_block_stream_parser_core.sv
tb/sv/tlv_event_checker.sv
tb/sv/tlv_block_stream_parser_core_tb.sv
